FILE: rtl/stok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared widths, token kinds, character constants, the token record and the
// classification helpers, the latter used by the scanner front end.
// ----------------------------------------------------------------------------
package stok_pkg;

    // Width of the running stream position (wraps modulo 2^POS_WIDTH).
    localparam int POS_WIDTH = 16;
    // Fixed width of the start and length fields of a token.
    localparam int TOK_WIDTH = 16;

    // Depth of the queue between the scanner and the output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [POS_WIDTH-1:0] pos_t;
    typedef logic [TOK_WIDTH-1:0] tok_field_t;

    localparam tok_field_t LEN_MAX = '1;

    // Token kinds as they appear on the result channel.
    typedef enum logic [3:0] {
        KIND_END    = 4'd0,
        KIND_I32    = 4'd1,
        KIND_I64    = 4'd2,
        KIND_RETURN = 4'd3,
        KIND_IDENT  = 4'd4,
        KIND_INT    = 4'd5,
        KIND_LPAREN = 4'd6,
        KIND_RPAREN = 4'd7,
        KIND_LBRACE = 4'd8,
        KIND_RBRACE = 4'd9,
        KIND_SEMI   = 4'd10,
        KIND_ASSIGN = 4'd11,
        KIND_PLUS   = 4'd12,
        KIND_BAD    = 4'd13
    } kind_t;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_6      = 8'h36;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // One token as produced by the scanner.
    typedef struct packed {
        kind_t      kind;
        tok_field_t start;
        tok_field_t length;
    } token_t;

    // Everything one input item causes: one or two tokens.
    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } pair_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || (c == CH_USCORE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) || (c == CH_LF);
    endfunction

    // Kind of a single-byte token; anything not listed is unexpected.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_SEMI:   k = KIND_SEMI;
            CH_ASSIGN: k = KIND_ASSIGN;
            CH_PLUS:   k = KIND_PLUS;
            default:   k = KIND_BAD;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/source_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer
// Streaming lexical scanner: one source byte in per item, tokens with kind,
// start offset and length out, keyword matching done on the fly.
//
//   Channel   Ports                                   Direction  Content
//   s_        s_valid/s_ready, s_char_byte           in         source byte
//   m_        m_valid/m_ready, m_token_kind,         out        one token
//             m_token_start, m_token_length,
//             m_last_of_run
//
// The scanner takes one byte per cycle while the queue is not full; a byte
// that causes tokens passes through the queue into the output register.
// A byte that causes two tokens gives two output items, so the output side
// sets the long-run rate at one token per cycle while m_ready stays high.
// A four-entry queue of token pairs parts the scanner from the output stage;
// s_ready falls only when that queue is full.
// Reset is synchronous and active low; it clears scanner state and the queue.
// ----------------------------------------------------------------------------
module source_tokenizer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output      logic         s_ready,
    input  wire logic [7:0]   s_char_byte,
    output      logic         m_valid,
    input  wire logic         m_ready,
    output      logic [3:0]   m_token_kind,
    output      logic [15:0]  m_token_start,
    output      logic [15:0]  m_token_length,
    output      logic         m_last_of_run
);

    logic                q_push, q_full, q_pop, q_valid;
    stok_pkg::pair_t     q_in, q_head;
    stok_pkg::token_t    out_tok;

    // Scanner front end.
    stok_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    // Queue of token pairs.
    stok_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Output stage.
    stok_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_tok   (out_tok),
        .m_last  (m_last_of_run)
    );

    assign m_token_kind   = out_tok.kind;
    assign m_token_start  = out_tok.start;
    assign m_token_length = out_tok.length;

endmodule
`default_nettype wire

FILE: rtl/stok_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer scanner front end
// Accepts one byte per cycle while the queue is not full, tracks the open
// token and the keyword flags, and pushes the tokens that each byte closes or opens into the queue.
// ----------------------------------------------------------------------------
module stok_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire logic [7:0]          s_char_byte,
    input  wire logic                q_full,
    output      logic                q_push,
    output      stok_pkg::pair_t     q_data
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_IDENT = 3'b010,
        MODE_INT   = 3'b100
    } mode_t;

    mode_t                   mode_reg, mode_next;
    stok_pkg::pos_t          pos_reg, pos_next;
    stok_pkg::pos_t          open_start_reg, open_start_next;
    stok_pkg::tok_field_t    open_len_reg, open_len_next;
    logic [2:0]              kw_reg, kw_next;

    logic                    accept;
    logic                    letter, digit, space;
    logic                    cont, closing, new_emit;
    stok_pkg::token_t        close_tok, new_tok;

    // Drop every keyword whose expected character at this offset differs.
    function automatic logic [2:0] kw_step(input logic [2:0] flags,
                                           input stok_pkg::tok_field_t idx,
                                           input logic [7:0] c);
        logic m0, m1, m2;
        m0 = (idx == stok_pkg::tok_field_t'(0) && c == stok_pkg::CH_I)
          || (idx == stok_pkg::tok_field_t'(1) && c == stok_pkg::CH_3)
          || (idx == stok_pkg::tok_field_t'(2) && c == stok_pkg::CH_2);
        m1 = (idx == stok_pkg::tok_field_t'(0) && c == stok_pkg::CH_I)
          || (idx == stok_pkg::tok_field_t'(1) && c == stok_pkg::CH_6)
          || (idx == stok_pkg::tok_field_t'(2) && c == stok_pkg::CH_4);
        m2 = (idx == stok_pkg::tok_field_t'(0) && c == stok_pkg::CH_R)
          || (idx == stok_pkg::tok_field_t'(1) && c == stok_pkg::CH_E)
          || (idx == stok_pkg::tok_field_t'(2) && c == stok_pkg::CH_T)
          || (idx == stok_pkg::tok_field_t'(3) && c == stok_pkg::CH_U)
          || (idx == stok_pkg::tok_field_t'(4) && c == stok_pkg::CH_R)
          || (idx == stok_pkg::tok_field_t'(5) && c == stok_pkg::CH_N);
        return flags & {m2, m1, m0};
    endfunction

    // An identifier is a keyword only if its flag survived and its length fits.
    function automatic stok_pkg::kind_t ident_kind(input logic [2:0] flags,
                                                   input stok_pkg::tok_field_t len);
        stok_pkg::kind_t k;
        if (flags[0] && len == stok_pkg::tok_field_t'(3)) begin
            k = stok_pkg::KIND_I32;
        end else if (flags[1] && len == stok_pkg::tok_field_t'(3)) begin
            k = stok_pkg::KIND_I64;
        end else if (flags[2] && len == stok_pkg::tok_field_t'(6)) begin
            k = stok_pkg::KIND_RETURN;
        end else begin
            k = stok_pkg::KIND_IDENT;
        end
        return k;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the byte and build the tokens it may cause.
    always_comb begin
        letter = stok_pkg::is_letter(s_char_byte);
        digit  = stok_pkg::is_digit(s_char_byte);
        space  = stok_pkg::is_space(s_char_byte);

        cont = ((mode_reg == MODE_IDENT) && (letter || digit))
            || ((mode_reg == MODE_INT) && digit);
        closing  = !cont && (mode_reg != MODE_IDLE);
        new_emit = !cont && ((s_char_byte == stok_pkg::CH_NUL)
                             || (!letter && !digit && !space));

        close_tok.kind   = (mode_reg == MODE_IDENT) ? ident_kind(kw_reg, open_len_reg)
                                                    : stok_pkg::KIND_INT;
        close_tok.start  = stok_pkg::tok_field_t'(open_start_reg);
        close_tok.length = open_len_reg;

        if (s_char_byte == stok_pkg::CH_NUL) begin
            new_tok.kind   = stok_pkg::KIND_END;
            new_tok.length = stok_pkg::tok_field_t'(0);
        end else begin
            new_tok.kind   = stok_pkg::single_kind(s_char_byte);
            new_tok.length = stok_pkg::tok_field_t'(1);
        end
        new_tok.start = stok_pkg::tok_field_t'(pos_reg);

        q_data.tok0 = closing ? close_tok : new_tok;
        q_data.tok1 = new_tok;
        q_data.two  = closing && new_emit;
        q_push      = accept && (closing || new_emit);
    end

    // Scanner state update.
    always_comb begin
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        open_start_next = open_start_reg;
        open_len_next   = open_len_reg;
        kw_next         = kw_reg;
        if (accept) begin
            if (cont) begin
                kw_next       = kw_step(kw_reg, open_len_reg, s_char_byte);
                open_len_next = (open_len_reg == stok_pkg::LEN_MAX) ? open_len_reg
                              : open_len_reg + stok_pkg::tok_field_t'(1);
                pos_next      = pos_reg + stok_pkg::pos_t'(1);
            end else begin
                mode_next     = MODE_IDLE;
                open_len_next = '0;
                kw_next       = 3'b111;
                if (s_char_byte == stok_pkg::CH_NUL) begin
                    open_start_next = '0;
                    pos_next        = '0;
                end else begin
                    if (letter || digit) begin
                        mode_next       = letter ? MODE_IDENT : MODE_INT;
                        open_start_next = pos_reg;
                        open_len_next   = stok_pkg::tok_field_t'(1);
                        kw_next         = kw_step(3'b111, '0, s_char_byte);
                    end
                    pos_next = pos_reg + stok_pkg::pos_t'(1);
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            pos_reg        <= '0;
            open_start_reg <= '0;
            open_len_reg   <= '0;
            kw_reg         <= 3'b111;
        end else begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            open_start_reg <= open_start_next;
            open_len_reg   <= open_len_next;
            kw_reg         <= kw_next;
        end
    end

`ifndef SYNTHESIS
    // An end byte returns the scanner to the start of a fresh stream.
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_char_byte == stok_pkg::CH_NUL)
        |=> (pos_reg == '0) && (mode_reg == MODE_IDLE))
        else $error("scanner did not restart after end byte");

    // While no token is open the keyword flags and length stay at rest.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (open_len_reg == '0) && (kw_reg == 3'b111))
        else $error("idle scanner holds stale token state");
`endif

endmodule
`default_nettype wire

FILE: rtl/stok_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer queue
// Short first-in first-out store of token pairs between scanner and output.
// ----------------------------------------------------------------------------
module stok_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire stok_pkg::pair_t     push_data,
    output      logic                full,
    input  wire logic                pop,
    output      logic                head_valid,
    output      stok_pkg::pair_t     head_data
);

    stok_pkg::pair_t                 mem [stok_pkg::QDEPTH];
    logic [stok_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [stok_pkg::QCNT_W-1:0]     count_reg;

    assign full       = (count_reg == stok_pkg::QCNT_W'(stok_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + stok_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + stok_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + stok_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - stok_pkg::QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    // The scanner never pushes into a full queue, the output never pops empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !head_valid))
        else $error("queue overflow or underflow");
`endif

endmodule
`default_nettype wire

FILE: rtl/stok_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer output stage
// Takes token pairs from the queue and presents them one token per item,
// marking the last token that a byte caused.
// ----------------------------------------------------------------------------
module stok_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire stok_pkg::pair_t     q_data,
    output      logic                q_pop,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      stok_pkg::token_t    m_tok,
    output      logic                m_last
);

    logic                m_valid_reg, m_valid_next;
    logic                last_reg, last_next;
    logic                pend_reg, pend_next;
    stok_pkg::token_t    tok_reg, tok_next;
    stok_pkg::token_t    pend_tok_reg, pend_tok_next;
    logic                out_free;

    // Refill the output register from the pending token or the queue head.
    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        m_valid_next  = m_valid_reg;
        last_next     = last_reg;
        pend_next     = pend_reg;
        tok_next      = tok_reg;
        pend_tok_next = pend_tok_reg;
        q_pop         = 1'b0;
        if (out_free) begin
            if (pend_reg) begin
                m_valid_next = 1'b1;
                tok_next     = pend_tok_reg;
                last_next    = 1'b1;
                pend_next    = 1'b0;
            end else if (q_valid) begin
                q_pop         = 1'b1;
                m_valid_next  = 1'b1;
                tok_next      = q_data.tok0;
                last_next     = !q_data.two;
                pend_next     = q_data.two;
                pend_tok_next = q_data.tok1;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        tok_reg      <= tok_next;
        last_reg     <= last_next;
        pend_tok_reg <= pend_tok_next;
    end

    assign m_valid = m_valid_reg;
    assign m_tok   = tok_reg;
    assign m_last  = last_reg;

`ifndef SYNTHESIS
    // A second token only waits behind a first one still on the output.
    a_pend_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> m_valid_reg && !last_reg)
        else $error("pending token without a first token shown");

    // Once the first of two tokens leaves, the second follows marked last.
    a_pend_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && m_ready |=> m_valid_reg && last_reg && !pend_reg)
        else $error("second token of a pair not delivered next");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Streams source bytes into the scanner and checks every token that comes
// out against a cycle-free software scanner kept in step with the input.
// Directed texts cover keywords, all symbols, blanks and bad bytes. Random
// texts follow, first with stalls on both channels and then without.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 100;
    localparam string ID_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string SYMBOLS = "(){};=+";

    // Scanner modes of the software model.
    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_NUMBER
    } lex_state_t;

    // One token as the result channel should carry it.
    typedef struct {
        stok_pkg::kind_t      kind;
        stok_pkg::tok_field_t start;
        stok_pkg::tok_field_t length;
        logic                 last;
    } token_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [15:0] m_token_start;
    logic [15:0] m_token_length;
    logic        m_last_of_run;

    // Software scanner state.
    lex_state_t            lex_state = LEX_IDLE;
    stok_pkg::tok_field_t  word_start = '0;
    stok_pkg::tok_field_t  word_len = '0;
    logic [2:0]            kw_alive = 3'b111;
    stok_pkg::pos_t        next_pos = '0;

    token_rec_t  tokens_due[$];
    int          error_count = 0;
    int          tokens_checked = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b0;
    int          stall_left = 0;
    logic        ready_next;

    source_tokenizer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_last_of_run  (m_last_of_run)
    );

    // Clock with a period of two time units.
    always #1 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still due",
                     cycle_count, tokens_due.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Character classes of the source language.
    function automatic bit starts_word(input logic [7:0] c);
        return (c >= stok_pkg::CH_LO_A && c <= stok_pkg::CH_LO_Z)
            || (c >= stok_pkg::CH_UP_A && c <= stok_pkg::CH_UP_Z)
            || c == stok_pkg::CH_USCORE;
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= stok_pkg::CH_ZERO && c <= stok_pkg::CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == stok_pkg::CH_SPACE || c == stok_pkg::CH_TAB
            || c == stok_pkg::CH_CR || c == stok_pkg::CH_LF;
    endfunction

    function automatic stok_pkg::kind_t symbol_kind(input logic [7:0] c);
        stok_pkg::kind_t k;
        case (c)
            stok_pkg::CH_LPAREN: k = stok_pkg::KIND_LPAREN;
            stok_pkg::CH_RPAREN: k = stok_pkg::KIND_RPAREN;
            stok_pkg::CH_LBRACE: k = stok_pkg::KIND_LBRACE;
            stok_pkg::CH_RBRACE: k = stok_pkg::KIND_RBRACE;
            stok_pkg::CH_SEMI:   k = stok_pkg::KIND_SEMI;
            stok_pkg::CH_ASSIGN: k = stok_pkg::KIND_ASSIGN;
            stok_pkg::CH_PLUS:   k = stok_pkg::KIND_PLUS;
            default:             k = stok_pkg::KIND_BAD;
        endcase
        return k;
    endfunction

    // Spelling of the keywords: 0 is i32, 1 is i64, 2 is return.
    function automatic int keyword_len(input int k);
        return (k == 2) ? 6 : 3;
    endfunction

    function automatic logic [7:0] keyword_char(input int k, input int idx);
        logic [7:0] c;
        c = 8'h00;
        if (k == 2) begin
            case (idx)
                0: c = stok_pkg::CH_R;
                1: c = stok_pkg::CH_E;
                2: c = stok_pkg::CH_T;
                3: c = stok_pkg::CH_U;
                4: c = stok_pkg::CH_R;
                5: c = stok_pkg::CH_N;
                default: c = 8'h00;
            endcase
        end else begin
            case (idx)
                0: c = stok_pkg::CH_I;
                1: c = (k == 0) ? stok_pkg::CH_3 : stok_pkg::CH_6;
                2: c = (k == 0) ? stok_pkg::CH_2 : stok_pkg::CH_4;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic stok_pkg::kind_t word_kind();
        stok_pkg::kind_t k;
        if (kw_alive[0] && word_len == 16'd3)
            k = stok_pkg::KIND_I32;
        else if (kw_alive[1] && word_len == 16'd3)
            k = stok_pkg::KIND_I64;
        else if (kw_alive[2] && word_len == 16'd6)
            k = stok_pkg::KIND_RETURN;
        else
            k = stok_pkg::KIND_IDENT;
        return k;
    endfunction

    // Adds one byte to the open token and narrows the keyword candidates.
    task automatic grow_word(input logic [7:0] c);
        int idx;
        idx = int'(word_len);
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k] && (idx >= keyword_len(k) || keyword_char(k, idx) != c))
                kw_alive[k] = 1'b0;
        end
        if (word_len != stok_pkg::LEN_MAX)
            word_len = word_len + 1'b1;
    endtask

    // Advances the software scanner by one byte and queues the tokens it gives.
    task automatic scan_byte(input logic [7:0] c);
        stok_pkg::pos_t       pos;
        stok_pkg::kind_t      kinds[2];
        stok_pkg::tok_field_t starts[2];
        stok_pkg::tok_field_t lens[2];
        int                   n;
        bit                   absorbed;
        token_rec_t           rec;
        pos = next_pos;
        n = 0;
        absorbed = 1'b0;
        // An open token either takes the byte or is closed by it.
        if (lex_state == LEX_WORD) begin
            if (starts_word(c) || is_numeral(c)) begin
                grow_word(c);
                absorbed = 1'b1;
            end else begin
                kinds[n] = word_kind();
                starts[n] = word_start;
                lens[n] = word_len;
                n++;
            end
        end else if (lex_state == LEX_NUMBER) begin
            if (is_numeral(c)) begin
                grow_word(c);
                absorbed = 1'b1;
            end else begin
                kinds[n] = stok_pkg::KIND_INT;
                starts[n] = word_start;
                lens[n] = word_len;
                n++;
            end
        end
        if (absorbed) begin
            next_pos = pos + 1'b1;
        end else begin
            lex_state = LEX_IDLE;
            word_len = '0;
            kw_alive = 3'b111;
            if (c == stok_pkg::CH_NUL) begin
                kinds[n] = stok_pkg::KIND_END;
                starts[n] = stok_pkg::tok_field_t'(pos);
                lens[n] = '0;
                n++;
                word_start = '0;
                next_pos = '0;
            end else begin
                if (starts_word(c) || is_numeral(c)) begin
                    lex_state = starts_word(c) ? LEX_WORD : LEX_NUMBER;
                    word_start = stok_pkg::tok_field_t'(pos);
                    grow_word(c);
                end else if (!is_blank(c)) begin
                    kinds[n] = symbol_kind(c);
                    starts[n] = stok_pkg::tok_field_t'(pos);
                    lens[n] = 16'd1;
                    n++;
                end
                next_pos = pos + 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            rec.kind = kinds[i];
            rec.start = starts[i];
            rec.length = lens[i];
            rec.last = (i == n - 1);
            tokens_due.push_back(rec);
        end
    endtask

    // Sends one byte, with an occasional idle burst before it.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_char_byte <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Receiver: ready with random stall bursts while idling is enabled.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            ready_next = 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_ready <= ready_next;
    end

    // Result checker: each accepted token against the oldest expected one.
    always @(posedge aclk) begin
        token_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                report_error($sformatf("token kind %0d start %0d with none expected",
                                       m_token_kind, m_token_start));
            end else begin
                want = tokens_due.pop_front();
                tokens_checked++;
                if (m_token_kind !== want.kind)
                    report_error($sformatf("kind %0d, expected %0d (start %0d)",
                                           m_token_kind, want.kind, want.start));
                if (m_token_start !== want.start)
                    report_error($sformatf("start %0d, expected %0d",
                                           m_token_start, want.start));
                if (m_token_length !== want.length)
                    report_error($sformatf("length %0d, expected %0d (start %0d)",
                                           m_token_length, want.length, want.start));
                if (m_last_of_run !== want.last)
                    report_error($sformatf("last_of_run %0b, expected %0b (start %0d)",
                                           m_last_of_run, want.last, want.start));
            end
        end
    end

    // Keywords, every symbol, word and number edges, ended by a zero byte.
    task automatic test_keywords_and_symbols();
        send_text("i32(i64)return{_Az9}0;=+");
        send_byte(stok_pkg::CH_NUL);
    endtask

    // Blanks are skipped, high and odd bytes are unexpected, a number is
    // closed by the end of the stream.
    task automatic test_blanks_and_bad_bytes();
        send_text(" \t\r\n@");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_text("12");
        send_byte(stok_pkg::CH_NUL);
    endtask

    // A random fragment of source text, mostly well formed.
    task automatic send_fragment();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 2))
                0: send_text("i32");
                1: send_text("i64");
                default: send_text("return");
            endcase
        end else if (r < 20) begin
            case ($urandom_range(0, 8))
                0: send_text("i3");
                1: send_text("i6");
                2: send_text("i324");
                3: send_text("i64x");
                4: send_text("retur");
                5: send_text("returns");
                6: send_text("I32");
                7: send_text("Return");
                default: send_text("i_32");
            endcase
        end else if (r < 40) begin
            n = $urandom_range(1, 8);
            send_byte(ID_CHARS[$urandom_range(0, 52)]);
            for (int i = 1; i < n; i++)
                send_byte(ID_CHARS[$urandom_range(0, 62)]);
        end else if (r < 52) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(stok_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (r < 70) begin
            send_byte(SYMBOLS[$urandom_range(0, 6)]);
        end else if (r < 85) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0: send_byte(stok_pkg::CH_SPACE);
                    1: send_byte(stok_pkg::CH_TAB);
                    2: send_byte(stok_pkg::CH_CR);
                    default: send_byte(stok_pkg::CH_LF);
                endcase
            end
        end else if (r < 90) begin
            send_byte(stok_pkg::CH_NUL);
        end else begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_text(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_fragment();
    endtask

    // Main sequence.
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        idle_on = 1'b1;
        test_keywords_and_symbols();
        test_blanks_and_bad_bytes();

        test_random_text(1000);
        idle_on = 1'b0;
        test_random_text(400);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d source bytes, checked %0d tokens, %0d mismatches",
                 bytes_sent, tokens_checked, error_count);
        $display("covered keywords, symbols, blanks, bad bytes and random text");
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
